### hdl/flag_byte_lz_line_decoder_macros.svh
// Assertion macros for the flag-byte LZ line decoder.
// Used by files that sample clk and arst_n; no other dependencies.
`ifndef FLAG_BYTE_LZ_LINE_DECODER_MACROS_SVH
`define FLAG_BYTE_LZ_LINE_DECODER_MACROS_SVH

// Same-cycle implication.
`define FBLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FBLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/fbld_pkg.sv
// Shared types, constants and the pixel interleave function for the decoder.
// No dependencies.
package fbld_pkg;

	localparam int WINDOW_DEPTH = 2048;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int DIST_W       = 16;
	localparam int EXT_W        = 18;
	localparam int NUM_DIST     = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;

	localparam logic [CFG_IDX_W-1:0] REG_DIST_0_3     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_4_7     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_8_11    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_12_15   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_UNITS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT   = 3'd5;

	localparam logic [7:0] LINE_UNITS_RST = 8'd80;
	localparam logic [9:0] LINE_COUNT_RST = 10'd400;
	localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;
	localparam logic [4:0] COPY_LEN_BIAS  = 5'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [7:0] line_units;
		logic [9:0] line_count;
	} geom_t;

	typedef struct packed {
		logic       clear;
		logic       push;
		logic       last_hint;
		logic [7:0] value;
	} emit_req_t;

	typedef struct packed {
		logic free;
		logic finished;
	} emit_sts_t;

	// bits 7,5,3,1 -> high nibble (pixel 0), bits 6,4,2,0 -> low nibble (pixel 1)
	function automatic logic [7:0] interleave(input logic [7:0] b);
		return {b[1], b[3], b[5], b[7], b[0], b[2], b[4], b[6]};
	endfunction

endpackage

### hdl/fbld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fbld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/fbld_emit.sv
// Output stage: line/image position tracking and the registered result word.
// Depends on fbld_pkg.
module fbld_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  fbld_pkg::geom_t   geom,
	input  fbld_pkg::emit_req_t req,
	output fbld_pkg::emit_sts_t sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        pixel_pair,
	output logic              line_end,
	output logic              image_end,
	output logic              last
);

	logic [9:0] bil_q, ln_q, bil_eff, ln_eff;
	logic       fin_q, fin_eff;
	logic       out_valid_q;
	logic [7:0] pixel_q;
	logic       lend_q, iend_q, last_q;
	logic [9:0] line_bytes;
	logic       lend, iend, load;

	always_comb begin
		bil_eff    = req.clear ? '0 : bil_q;
		ln_eff     = req.clear ? '0 : ln_q;
		fin_eff    = req.clear ? 1'b0 : fin_q;
		line_bytes = {geom.line_units, 2'b00};
		lend       = ({1'b0, bil_eff} + 11'd1) >= {1'b0, line_bytes};
		iend       = lend && (({1'b0, ln_eff} + 11'd1) >= {1'b0, geom.line_count});
		load       = req.push && !fin_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bil_q       <= '0;
			ln_q        <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				bil_q <= lend ? '0 : bil_eff + 10'd1;
				ln_q  <= lend ? ln_eff + 10'd1 : ln_eff;
				fin_q <= iend;
			end else begin
				bil_q <= bil_eff;
				ln_q  <= ln_eff;
				fin_q <= fin_eff;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_q <= fbld_pkg::interleave(req.value);
			lend_q  <= lend;
			iend_q  <= iend;
			last_q  <= req.last_hint || iend;
		end
	end

	assign sts.free     = !out_valid_q || !out_stall;
	assign sts.finished = fin_q;
	assign out_valid    = out_valid_q;
	assign pixel_pair   = pixel_q;
	assign line_end     = lend_q;
	assign image_end    = iend_q;
	assign last         = last_q;

endmodule

### hdl/flag_byte_lz_line_decoder.sv
// Flag-byte LZ line decoder; history is a 2048 x 8 RAM. Flag and literal bytes are
// taken in IDLE; a copy token (len 2..17) does one history read then one write per
// byte. A literal's word is valid the cycle after its byte; a copy's word follows
// READ, WRITE and the output register. A word held by out_stall stalls input, and
// a copy unless the image is done. arst_n clears control, counters and config
// (line_units 80, line_count 400); RAM is not cleared; unwritten data is never used.
module flag_byte_lz_line_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fbld_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbld_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      code_byte,
	input  logic                            image_start,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      pixel_pair,
	output logic                            line_end,
	output logic                            image_end,
	output logic                            last
);

`include "flag_byte_lz_line_decoder_macros.svh"

	localparam int AW = fbld_pkg::ADDR_W;
	localparam int CW = fbld_pkg::CNT_W;
	localparam int DW = fbld_pkg::DIST_W;
	localparam int XW = fbld_pkg::EXT_W;

	// ---- configuration ----
	logic [DW-1:0]   dist_q [fbld_pkg::NUM_DIST];
	fbld_pkg::geom_t geom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fbld_pkg::NUM_DIST; i++) begin
				dist_q[i] <= '0;
			end
			geom_q.line_units <= fbld_pkg::LINE_UNITS_RST;
			geom_q.line_count <= fbld_pkg::LINE_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fbld_pkg::REG_DIST_0_3, fbld_pkg::REG_DIST_4_7,
				fbld_pkg::REG_DIST_8_11, fbld_pkg::REG_DIST_12_15: begin
					// four 16-bit distances per register, lowest entry in low bits
					for (int k = 0; k < 4; k++) begin
						dist_q[{cfg_index[1:0], 2'(k)}] <= cfg_data[16*k +: 16];
					end
				end
				fbld_pkg::REG_LINE_UNITS: geom_q.line_units <= cfg_data[7:0];
				fbld_pkg::REG_LINE_COUNT: geom_q.line_count <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// ---- decoder state ----
	fbld_pkg::state_t state_q, state_d;
	logic [7:0]    flag_shift_q, flag_shift_d;
	logic [3:0]    flags_left_q, flags_left_d;
	logic [AW-1:0] wp_q, wp_d;          // history write position
	logic [CW-1:0] bdec_q, bdec_d;      // bytes decoded, saturates at window depth
	logic [DW-1:0] cdist_q, cdist_d;    // distance of the running copy
	logic [4:0]    remain_q, remain_d;  // copy bytes still to produce
	logic          src_ok_q, src_ok_d;  // current copy byte has a valid source

	// effective values after an image_start clear
	logic [7:0]    fs_eff;
	logic [3:0]    fl_eff;
	logic [AW-1:0] wp_eff;
	logic [CW-1:0] bdec_eff;

	logic          accept;
	logic          hist_we, hist_re;
	logic [AW-1:0] raddr;
	logic [7:0]    hist_wdata, hist_rdata;
	logic [XW-1:0] wp_x, dist_x;

	fbld_pkg::emit_req_t req;
	fbld_pkg::emit_sts_t sts;

	// One byte per accept, and only from IDLE with room in the output register.
	assign in_stall = (state_q != fbld_pkg::ST_IDLE) || !sts.free;
	assign accept   = in_valid && !in_stall;

	assign wp_x   = XW'(wp_q);
	assign dist_x = XW'(cdist_q);

	always_comb begin
		state_d      = state_q;
		fs_eff       = (accept && image_start) ? '0 : flag_shift_q;
		fl_eff       = (accept && image_start) ? '0 : flags_left_q;
		wp_eff       = (accept && image_start) ? '0 : wp_q;
		bdec_eff     = (accept && image_start) ? '0 : bdec_q;
		flag_shift_d = fs_eff;
		flags_left_d = fl_eff;
		cdist_d      = cdist_q;
		remain_d     = remain_q;
		src_ok_d     = src_ok_q;
		hist_we      = 1'b0;
		hist_wdata   = code_byte;
		hist_re      = 1'b0;
		raddr        = '0;
		req.clear    = accept && image_start;
		req.push     = 1'b0;
		req.last_hint = 1'b1;
		req.value    = code_byte;

		case (state_q)
			fbld_pkg::ST_IDLE: begin
				if (accept) begin
					if (fl_eff == '0) begin
						// flag byte: eight token flags, MSB first
						flag_shift_d = code_byte;
						flags_left_d = fbld_pkg::FLAGS_PER_BYTE;
					end else begin
						flag_shift_d = {fs_eff[6:0], 1'b0};
						flags_left_d = fl_eff - 4'd1;
						if (fs_eff[7]) begin
							cdist_d  = dist_q[code_byte[7:4]];
							remain_d = {1'b0, code_byte[3:0]} + fbld_pkg::COPY_LEN_BIAS;
							state_d  = fbld_pkg::ST_READ;
						end else begin
							hist_we  = 1'b1;
							req.push = 1'b1;
						end
					end
				end
			end
			fbld_pkg::ST_READ: begin
				// zero, beyond what was decoded, or beyond the window -> byte is 0
				src_ok_d = (cdist_q != '0) && (XW'(cdist_q) <= XW'(bdec_q)) &&
					(XW'(cdist_q) <= XW'(fbld_pkg::WINDOW_DEPTH));
				hist_re  = 1'b1;
				raddr    = (wp_x >= dist_x) ? AW'(wp_x - dist_x) :
					AW'(wp_x + XW'(fbld_pkg::WINDOW_DEPTH) - dist_x);
				state_d  = fbld_pkg::ST_WRITE;
			end
			fbld_pkg::ST_WRITE: begin
				// write-back waits for the output register unless output is muted
				hist_wdata    = src_ok_q ? hist_rdata : 8'h00;
				req.value     = hist_wdata;
				req.last_hint = (remain_q == 5'd1);
				if (sts.free || sts.finished) begin
					hist_we  = 1'b1;
					req.push = 1'b1;
					remain_d = remain_q - 5'd1;
					state_d  = (remain_q == 5'd1) ? fbld_pkg::ST_IDLE : fbld_pkg::ST_READ;
				end
			end
			default: state_d = fbld_pkg::ST_IDLE;
		endcase

		wp_d   = wp_eff;
		bdec_d = bdec_eff;
		if (hist_we) begin
			wp_d = (wp_eff == AW'(fbld_pkg::WINDOW_DEPTH - 1)) ? '0 : wp_eff + AW'(1);
			if (bdec_eff < CW'(fbld_pkg::WINDOW_DEPTH)) begin
				bdec_d = bdec_eff + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fbld_pkg::ST_IDLE;
			flag_shift_q <= '0;
			flags_left_q <= '0;
			wp_q         <= '0;
			bdec_q       <= '0;
			remain_q     <= '0;
		end else begin
			state_q      <= state_d;
			flag_shift_q <= flag_shift_d;
			flags_left_q <= flags_left_d;
			wp_q         <= wp_d;
			bdec_q       <= bdec_d;
			remain_q     <= remain_d;
		end
	end

	always_ff @(posedge clk) begin
		cdist_q  <= cdist_d;
		src_ok_q <= src_ok_d;
	end

	// history window; read issued in READ, data used in WRITE
	fbld_ram #(
		.WIDTH(8),
		.DEPTH(fbld_pkg::WINDOW_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (wp_eff),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (raddr),
		.rdata (hist_rdata)
	);

	fbld_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom_q),
		.req        (req),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_pair (pixel_pair),
		.line_end   (line_end),
		.image_end  (image_end),
		.last       (last)
	);

	`FBLD_ASSERT_NEXT(a_read_then_write, state_q == fbld_pkg::ST_READ, state_q == fbld_pkg::ST_WRITE, "copy read not followed by write")
	`FBLD_ASSERT_NOW(a_copy_len_live, state_q != fbld_pkg::ST_IDLE, remain_q != 5'd0, "copy running with no bytes left")
	`FBLD_ASSERT_NOW(a_bdec_sat, 1'b1, bdec_q <= CW'(fbld_pkg::WINDOW_DEPTH), "decoded count past window depth")
	`FBLD_ASSERT_NOW(a_no_write_in_read, state_q == fbld_pkg::ST_READ, !hist_we, "history written during copy read")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for flag_byte_lz_line_decoder: code words in, pixel words out.
// Needs fbld_pkg and the decoder RTL; predicts every pixel word with its own LZ decoder.

module testbench;

	// Unused register indexes; writes there must leave the block unchanged.
	localparam logic [fbld_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [fbld_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	// No accepted word in this many busy cycles means the block is hung.
	// Worst legal gap is a full-length copy plus a short random stall.
	localparam int STALL_LIMIT   = 4000;
	// Quiet time before a register write and at the end: covers a copy that
	// runs past the image and so leaves nothing expected to wait on.
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		logic [7:0] code;
		logic       start;
	} code_word_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       line_end;
		logic       image_end;
		logic       last;
	} pixel_word_t;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_we      = 1'b0;
	logic [fbld_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [fbld_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_stall;
	logic [7:0]                      code_byte   = '0;
	logic                            image_start = 1'b0;
	logic                            out_valid;
	logic                            out_stall   = 1'b0;
	logic [7:0]                      pixel_pair;
	logic                            line_end;
	logic                            image_end;
	logic                            last;

	code_word_t  code_words_todo[$];  // stimulus not yet presented
	pixel_word_t pixel_words_due[$];  // predicted output, oldest first

	int errors         = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;

	// Predictor state: configuration mirror plus decoder state.
	logic [63:0]                 dist_regs [4];
	logic [7:0]                  geom_units;
	logic [9:0]                  geom_lines;
	logic [7:0]                  hist [fbld_pkg::WINDOW_DEPTH];
	logic [fbld_pkg::ADDR_W-1:0] wr_pos;
	logic [fbld_pkg::CNT_W-1:0]  fill;         // bytes since image start, saturating
	logic [7:0]                  flag_bits;
	logic [3:0]                  tokens_left;
	logic [9:0]                  col;
	logic [9:0]                  row;
	logic                        done_img;

	flag_byte_lz_line_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_byte   (code_byte),
		.image_start (image_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_pair  (pixel_pair),
		.line_end    (line_end),
		.image_end   (image_end),
		.last        (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// Odd input bits go to the high pixel, even bits to the low pixel.
	function automatic logic [7:0] spread_bits(input logic [7:0] b);
		logic [7:0] p;
		for (int i = 0; i < 4; i++) begin
			p[4+i] = b[7-2*i];
			p[i]   = b[6-2*i];
		end
		return p;
	endfunction

	task automatic clear_image();
		wr_pos      = '0;
		fill        = '0;
		flag_bits   = '0;
		tokens_left = '0;
		col         = '0;
		row         = '0;
		done_img    = 1'b0;
	endtask

	// Copy source; a distance of zero, past the image start or past the
	// window reads as zero, so unwritten history is never touched.
	function automatic logic [7:0] history_at(input logic [15:0] back);
		if (back == 16'd0 || back > fill || back > fbld_pkg::WINDOW_DEPTH)
			return 8'h00;
		return hist[wr_pos - back[fbld_pkg::ADDR_W-1:0]];
	endfunction

	// Stores one decoded byte; while the image lasts it yields a pixel word.
	// The newest word is held back so the caller can mark it last.
	task automatic put_byte(input logic [7:0] value, inout pixel_word_t held,
			inout bit have_held);
		int          span;
		pixel_word_t w;
		hist[wr_pos] = value;
		wr_pos = wr_pos + 1'b1;
		if (fill < fbld_pkg::WINDOW_DEPTH)
			fill = fill + 1'b1;
		if (done_img)
			return;
		span        = int'(geom_units) * 4;
		w.pixel     = spread_bits(value);
		w.line_end  = (int'(col) + 1 >= span);
		w.image_end = 1'b0;
		w.last      = 1'b0;
		if (w.line_end) begin
			col         = '0;
			w.image_end = (int'(row) + 1 >= int'(geom_lines));
			row         = row + 1'b1;
			if (w.image_end)
				done_img = 1'b1;
		end else begin
			col = col + 1'b1;
		end
		if (have_held)
			pixel_words_due.push_back(held);
		held      = w;
		have_held = 1'b1;
	endtask

	// Decodes one accepted code word into the pixel words it causes.
	task automatic lz_decode(input code_word_t cw);
		pixel_word_t held;
		bit          have_held;
		bit          copy_tok;
		logic [3:0]  sel;
		logic [15:0] copy_back;
		int          len;
		have_held = 1'b0;
		held      = '0;
		if (cw.start)
			clear_image();
		if (tokens_left == 4'd0) begin
			flag_bits   = cw.code;
			tokens_left = fbld_pkg::FLAGS_PER_BYTE;
			return;
		end
		copy_tok    = flag_bits[7];
		flag_bits   = flag_bits << 1;
		tokens_left = tokens_left - 1'b1;
		if (copy_tok) begin
			sel       = cw.code[7:4];
			copy_back = dist_regs[sel[3:2]][16*int'(sel[1:0]) +: 16];
			len       = int'(cw.code[3:0]) + int'(fbld_pkg::COPY_LEN_BIAS);
			for (int i = 0; i < len; i++)
				put_byte(history_at(copy_back), held, have_held);
		end else begin
			put_byte(cw.code, held, have_held);
		end
		if (have_held) begin
			held.last = 1'b1;
			pixel_words_due.push_back(held);
		end
	endtask

	// ---------------------------------------------------------------
	// Driver: presents queued code words; holds a stalled word steady.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive
		code_word_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				lz_decode('{code: code_byte, start: image_start});
			if (!in_valid || !in_stall) begin
				if (code_words_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = code_words_todo.pop_front();
					code_byte   <= nxt.code;
					image_start <= nxt.start;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: checks each accepted pixel word against the oldest one due.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_word_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixel_words_due.size() == 0) begin
					$error("unexpected word: pixel_pair %h", pixel_pair);
					errors = errors + 1;
				end else begin
					w = pixel_words_due.pop_front();
					if (w.pixel !== pixel_pair) begin
						$error("pixel_pair: expected %h, got %h", w.pixel, pixel_pair);
						errors = errors + 1;
					end
					if (w.line_end !== line_end) begin
						$error("line_end: expected %b, got %b", w.line_end, line_end);
						errors = errors + 1;
					end
					if (w.image_end !== image_end) begin
						$error("image_end: expected %b, got %b", w.image_end, image_end);
						errors = errors + 1;
					end
					if (w.last !== last) begin
						$error("last: expected %b, got %b", w.last, last);
						errors = errors + 1;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: only counts while work is outstanding.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(code_words_todo.size() == 0 && !in_valid && pixel_words_due.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Register write; the mirror is updated too since the block is idle.
	task automatic write_reg(input logic [fbld_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			fbld_pkg::REG_DIST_0_3:   dist_regs[0] = val;
			fbld_pkg::REG_DIST_4_7:   dist_regs[1] = val;
			fbld_pkg::REG_DIST_8_11:  dist_regs[2] = val;
			fbld_pkg::REG_DIST_12_15: dist_regs[3] = val;
			fbld_pkg::REG_LINE_UNITS: geom_units   = val[7:0];
			fbld_pkg::REG_LINE_COUNT: geom_lines   = val[9:0];
			default: ;
		endcase
	endtask

	// Mostly short distances so copies hit real history; the rest are the
	// edges: zero, window limits and beyond.
	function automatic logic [15:0] pick_distance();
		if ($urandom_range(99) < 70)
			return 16'($urandom_range(40, 1));
		case ($urandom_range(5))
			0:       return 16'd0;
			1:       return 16'd2047;
			2:       return 16'd2048;
			3:       return 16'd2049;
			4:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_distances();
		write_reg(fbld_pkg::REG_DIST_0_3,
			{pick_distance(), pick_distance(), pick_distance(), pick_distance()});
		write_reg(fbld_pkg::REG_DIST_4_7,
			{pick_distance(), pick_distance(), pick_distance(), pick_distance()});
		write_reg(fbld_pkg::REG_DIST_8_11,
			{pick_distance(), pick_distance(), pick_distance(), pick_distance()});
		write_reg(fbld_pkg::REG_DIST_12_15,
			{pick_distance(), pick_distance(), pick_distance(), pick_distance()});
	endtask

	// Idle modes: none, sender gaps, receiver stalls, both.
	task automatic set_idle(input int mode);
		case (mode % 4)
			0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
			default: begin send_idle_pct = 24; recv_stall_pct = 24; end
		endcase
	endtask

	task automatic add(input logic start, input logic [7:0] code);
		code_words_todo.push_back('{code: code, start: start});
	endtask

	// Random image streams. The first word starts an image; further starts
	// come at 1 in odds (0: never) and often cut a flag group short.
	// long_mode favors all-copy flag bytes and 17-byte copies to fill and
	// wrap the history window.
	task automatic queue_random(input int count, input int odds, input bit long_mode);
		code_word_t cw;
		int         left;
		left = 0;
		for (int i = 0; i < count; i++) begin
			cw.start = (i == 0) || (odds > 0 && $urandom_range(odds - 1) == 0);
			if (cw.start)
				left = 0;
			if (left == 0) begin
				cw.code = (long_mode && $urandom_range(7) != 0) ? 8'hFF : 8'($urandom);
				left    = int'(fbld_pkg::FLAGS_PER_BYTE);
			end else begin
				cw.code = (long_mode && $urandom_range(7) != 0) ?
					{4'($urandom), 4'hF} : 8'($urandom);
				left    = left - 1;
			end
			code_words_todo.push_back(cw);
		end
	endtask

	// Wait for every word to go through, then let the block settle.
	task automatic drain();
		while (code_words_todo.size() != 0 || in_valid || pixel_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		for (int k = 0; k < 4; k++)
			dist_regs[k] = '0;
		geom_units = fbld_pkg::LINE_UNITS_RST;
		geom_lines = fbld_pkg::LINE_COUNT_RST;
		clear_image();

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset configuration: all distances zero, so both copies give
		// zeros; then literal extremes.
		set_idle(0);
		add(1'b0, 8'hC0);
		add(1'b0, 8'h0F);
		add(1'b0, 8'hFF);
		add(1'b0, 8'hFF);
		add(1'b0, 8'h00);
		add(1'b0, 8'hAA);
		add(1'b0, 8'h55);
		add(1'b0, 8'h80);
		add(1'b0, 8'h01);
		drain();

		// Entries 0..7: 1, 2, 0, 3, 2048, 2049, 65535, 5.
		write_reg(fbld_pkg::REG_DIST_0_3,   {16'd3, 16'd0, 16'd2, 16'd1});
		write_reg(fbld_pkg::REG_DIST_4_7,   {16'd5, 16'hFFFF, 16'd2049, 16'd2048});
		write_reg(fbld_pkg::REG_DIST_8_11,
			{pick_distance(), pick_distance(), pick_distance(), pick_distance()});
		write_reg(fbld_pkg::REG_DIST_12_15,
			{pick_distance(), pick_distance(), pick_distance(), pick_distance()});
		write_reg(fbld_pkg::REG_LINE_UNITS, 64'd1);   // 4 bytes per line
		write_reg(fbld_pkg::REG_LINE_COUNT, 64'd3);   // 12-byte image

		// Valid short copies, then a 17-byte copy that the image end cuts,
		// then a zero-distance and a 2048-distance copy past the image.
		add(1'b1, 8'h3C);
		add(1'b0, 8'h12);
		add(1'b0, 8'h34);
		add(1'b0, 8'h00);
		add(1'b0, 8'h1F);
		add(1'b0, 8'h23);
		add(1'b0, 8'h4A);
		add(1'b0, 8'hFF);
		add(1'b0, 8'h00);
		// New image: a valid short copy, a 65535 copy, a valid copy that runs
		// into the image end, and a copy past the image.
		add(1'b1, 8'h0F);
		add(1'b0, 8'h80);
		add(1'b0, 8'h01);
		add(1'b0, 8'hAA);
		add(1'b0, 8'h55);
		add(1'b0, 8'h30);
		add(1'b0, 8'h61);
		add(1'b0, 8'h12);
		add(1'b0, 8'h7F);
		drain();

		// Smallest image: one 4-byte line.
		set_idle(1);
		random_distances();
		write_reg(fbld_pkg::REG_LINE_UNITS, 64'd1);
		write_reg(fbld_pkg::REG_LINE_COUNT, 64'd1);
		queue_random(35, 6, 1'b0);
		drain();

		// Largest geometry and one long image that wraps the window;
		// the top two distances sit at the window edge.
		set_idle(2);
		random_distances();
		write_reg(fbld_pkg::REG_DIST_12_15,
			{16'd2047, 16'd2048, pick_distance(), pick_distance()});
		write_reg(fbld_pkg::REG_LINE_UNITS, 64'd255);
		write_reg(fbld_pkg::REG_LINE_COUNT, 64'd1023);
		queue_random(200, 0, 1'b1);
		drain();

		// Masked-to-zero geometry: every byte ends a line and the first
		// ends the image. Spare indexes must be ignored.
		set_idle(3);
		random_distances();
		write_reg(fbld_pkg::REG_LINE_UNITS, 64'hFFFF_FFFF_FFFF_FF00);
		write_reg(fbld_pkg::REG_LINE_COUNT, 64'hFFFF_FFFF_FFFF_FC00);
		write_reg(REG_SPARE_6, {$urandom, $urandom});
		write_reg(REG_SPARE_7, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_random(30, 8, 1'b0);
		drain();

		// Small random images, frequent line and image ends.
		set_idle(0);
		random_distances();
		write_reg(fbld_pkg::REG_LINE_UNITS, 64'($urandom_range(4, 1)));
		write_reg(fbld_pkg::REG_LINE_COUNT, 64'($urandom_range(6, 1)));
		queue_random(45, 25, 1'b0);
		drain();

		set_idle(1);
		random_distances();
		write_reg(fbld_pkg::REG_LINE_UNITS, 64'($urandom_range(8, 2)));
		write_reg(fbld_pkg::REG_LINE_COUNT, 64'($urandom_range(10, 2)));
		queue_random(45, 30, 1'b0);
		drain();

		// Garbage above the register widths must be masked off.
		set_idle(2);
		random_distances();
		write_reg(fbld_pkg::REG_LINE_UNITS,
			{56'({$urandom, $urandom}), 8'($urandom_range(3, 1))});
		write_reg(fbld_pkg::REG_LINE_COUNT,
			{54'({$urandom, $urandom}), 10'($urandom_range(4, 1))});
		queue_random(30, 12, 1'b0);
		drain();

		if (errors == 0 && pixel_words_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### flag_byte_lz_line_decoder.f
+incdir+hdl
hdl/fbld_pkg.sv
hdl/fbld_ram.sv
hdl/fbld_emit.sv
hdl/flag_byte_lz_line_decoder.sv
tb/testbench.sv
